FILE: rtl/core/cvsd_pkg.sv
`default_nettype none
package cvsd_pkg;
	localparam int PRICE_W = 32;
	localparam int TIME_W = 48;
	localparam int LAG_W = 32;
	localparam int SPREAD_W = 24;
	localparam int ID_W = 32;
	localparam int FRAC_BITS = 8;
	localparam int SCALE = 20000 << FRAC_BITS;
	localparam int SCALE_W = 23;
	// |diff| * SCALE, and the quotient
	localparam int NUM_W = PRICE_W + SCALE_W;
	localparam int SUM_W = PRICE_W + 1;
	localparam int CNT_W = 6;

	localparam logic [1:0] REG_MIN_LAG = 2'd0;
	localparam logic [1:0] REG_MAX_LAG = 2'd1;
	localparam logic [1:0] REG_MIN_SPREAD = 2'd2;

	typedef struct packed {
		logic [PRICE_W-1:0] ref_bid;
		logic [PRICE_W-1:0] ref_ask;
		logic [TIME_W-1:0] ref_time;
		logic [PRICE_W-1:0] tgt_bid;
		logic [PRICE_W-1:0] tgt_ask;
		logic [TIME_W-1:0] tgt_time;
	} snap_t;

	typedef struct packed {
		logic [ID_W-1:0] signal_id;
		logic side;
		logic [SPREAD_W-1:0] entry_spread;
		logic [TIME_W-1:0] signal_time;
		logic [LAG_W-1:0] venue_lag;
		logic [PRICE_W-1:0] out_ref_bid;
		logic [PRICE_W-1:0] out_ref_ask;
		logic [PRICE_W-1:0] out_tgt_bid;
		logic [PRICE_W-1:0] out_tgt_ask;
		logic [TIME_W-1:0] out_tgt_time;
		logic last;
	} result_t;

	typedef struct packed {
		logic load;     // capture snapshot, start divide for side 0
		logic next_side; // start divide for side 1
		logic div_step;
		logic eval;     // evaluate current side, update arm bit
		logic emit;     // load output register for current side
		logic last;
		logic side;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic fire;
		logic fire1;
	} stat_t;
endpackage
`default_nettype wire

FILE: rtl/core/cvsd_if.sv
`default_nettype none
interface cvsd_snap_if;
	logic valid;
	logic ready;
	cvsd_pkg::snap_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cvsd_res_if;
	logic valid;
	logic ready;
	cvsd_pkg::result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cvsd_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [31:0] wdata;
	modport source(output valid, output index, output wdata, input ready);
	modport sink(input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/cvsd_datapath.sv
`default_nettype none
module cvsd_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire cvsd_pkg::snap_t snap,
	input wire cvsd_pkg::cmd_t cmd,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_wdata,
	output cvsd_pkg::stat_t stat,
	output cvsd_pkg::result_t res
);
	import cvsd_pkg::*;

	logic [LAG_W-1:0] min_lag_q, max_lag_q;
	logic signed [SPREAD_W-1:0] min_spread_q;
	snap_t snap_q;
	logic [TIME_W-1:0] lag_q;
	logic [1:0] armed_q;
	logic [ID_W-1:0] id_q;
	logic [1:0] fire_q;
	logic signed [SPREAD_W-1:0] sp_q [2];

	// restoring divider, one quotient bit per cycle
	logic [NUM_W-1:0] num_q;
	logic [SUM_W-1:0] den_q;
	logic [SUM_W:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic neg_q, zero_q;

	logic [PRICE_W-1:0] a, b;
	logic [SUM_W-1:0] sum;
	logic [PRICE_W-1:0] diff;
	logic [SUM_W+1:0] rtry;
	logic [SUM_W:0] rsh;
	logic signed [NUM_W:0] qs;
	logic signed [SPREAD_W-1:0] sp_now;
	logic ok;
	logic [TIME_W-1:0] lag_now;

	always_comb begin
		if (cmd.load) begin
			a = snap.ref_bid;
			b = snap.tgt_ask;
		end else begin
			a = snap_q.tgt_bid;
			b = snap_q.ref_ask;
		end
		sum = {1'b0, a} + {1'b0, b};
		diff = (a >= b) ? a - b : b - a;
		rsh = {rem_q[SUM_W-1:0], num_q[NUM_W-1]};
		rtry = {1'b0, rsh} - {2'b00, den_q};
		qs = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
		sp_now = qs[SPREAD_W-1:0];
		lag_now = (snap.ref_time > snap.tgt_time) ? snap.ref_time - snap.tgt_time : '0;
		ok = !zero_q && lag_q >= {16'd0, min_lag_q} && lag_q <= {16'd0, max_lag_q}
			&& sp_now >= min_spread_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_lag_q <= '0;
			max_lag_q <= '1;
			min_spread_q <= '0;
			armed_q <= '0;
			id_q <= '0;
			fire_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_LAG: min_lag_q <= cfg_wdata;
					REG_MAX_LAG: max_lag_q <= cfg_wdata;
					REG_MIN_SPREAD: min_spread_q <= cfg_wdata[SPREAD_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load || cmd.next_side)
				cnt_q <= CNT_W'(NUM_W);
			else if (cmd.div_step && cnt_q != '0)
				cnt_q <= cnt_q - 1'b1;
			if (cmd.eval) begin
				armed_q[cmd.side] <= ok;
				fire_q[cmd.side] <= ok && !armed_q[cmd.side];
			end
			if (cmd.emit)
				id_q <= id_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			snap_q <= snap;
			lag_q <= lag_now;
		end
		if (cmd.load || cmd.next_side) begin
			num_q <= NUM_W'(diff) * NUM_W'(SCALE);
			den_q <= sum;
			rem_q <= '0;
			neg_q <= a < b;
			zero_q <= sum == '0;
		end else if (cmd.div_step && cnt_q != '0) begin
			if (!rtry[SUM_W+1]) begin
				rem_q <= rtry[SUM_W:0];
				num_q <= {num_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rsh;
				num_q <= {num_q[NUM_W-2:0], 1'b0};
			end
		end
		if (cmd.eval)
			sp_q[cmd.side] <= sp_now;
		if (cmd.emit) begin
			res.signal_id <= id_q;
			res.side <= cmd.side;
			res.entry_spread <= sp_q[cmd.side];
			res.signal_time <= snap_q.ref_time;
			res.venue_lag <= lag_q[LAG_W-1:0];
			res.out_ref_bid <= snap_q.ref_bid;
			res.out_ref_ask <= snap_q.ref_ask;
			res.out_tgt_bid <= snap_q.tgt_bid;
			res.out_tgt_ask <= snap_q.tgt_ask;
			res.out_tgt_time <= snap_q.tgt_time;
			res.last <= cmd.last;
		end
	end

	assign stat.div_done = cnt_q == '0;
	assign stat.fire = fire_q[0];
	assign stat.fire1 = fire_q[1];
endmodule
`default_nettype wire

FILE: rtl/core/cvsd_ctrl.sv
`default_nettype none
module cvsd_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire cvsd_pkg::stat_t stat,
	output cvsd_pkg::cmd_t cmd
);
	import cvsd_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV0 = 3'd1;
	localparam logic [2:0] S_DIV1 = 3'd2;
	localparam logic [2:0] S_EMIT0 = 3'd3;
	localparam logic [2:0] S_EMIT1 = 3'd4;

	logic [2:0] state_q, state_d;
	logic ov_q, ov_d;
	logic free;

	always_comb begin
		free = !ov_q || out_ready;
		state_d = state_q;
		ov_d = ov_q && !out_ready;
		cmd = '0;
		in_ready = state_q == S_IDLE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DIV0;
				end
			end
			S_DIV0: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					cmd.div_step = 1'b0;
					cmd.eval = 1'b1;
					cmd.next_side = 1'b1;
					state_d = S_DIV1;
				end
			end
			S_DIV1: begin
				cmd.side = 1'b1;
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					cmd.div_step = 1'b0;
					cmd.eval = 1'b1;
					state_d = S_EMIT0;
				end
			end
			S_EMIT0: begin
				if (!stat.fire)
					state_d = S_EMIT1;
				else if (free) begin
					cmd.emit = 1'b1;
					cmd.last = !stat.fire1;
					ov_d = 1'b1;
					state_d = stat.fire1 ? S_EMIT1 : S_IDLE;
				end
			end
			S_EMIT1: begin
				cmd.side = 1'b1;
				if (!stat.fire1)
					state_d = S_IDLE;
				else if (free) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					ov_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
		end
	end

	assign out_valid = ov_q;
endmodule
`default_nettype wire

FILE: rtl/core/cross_venue_spread_signal_detector_top.sv
// channel | dir | payload
// snap    | in  | ref/tgt bid, ask, time
// res     | out | signal record, last marks final of a snapshot
// cfg     | in  | index 0 min_lag, 1 max_lag, 2 min_spread
// Each snapshot runs two 55-step serial divides, one per side,
// through one shared restoring divider, then up to two result transfers.
// Reset clears registers to defaults, arm bits and id counter.
// The output register holds a result until taken; a stalled output holds the controller.
`default_nettype none
module cross_venue_spread_signal_detector_top (
	input wire logic clk,
	input wire logic arst_n,
	cvsd_snap_if.sink snap,
	cvsd_res_if.source res,
	cvsd_cfg_if.sink cfg
);
	import cvsd_pkg::*;

	cmd_t cmd;
	stat_t stat;

	assign cfg.ready = 1'b1;

	cvsd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(snap.valid), .in_ready(snap.ready),
		.out_valid(res.valid), .out_ready(res.ready),
		.stat(stat), .cmd(cmd)
	);

	cvsd_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.snap(snap.data), .cmd(cmd),
		.cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_wdata(cfg.wdata),
		.stat(stat), .res(res.data)
	);
endmodule
`default_nettype wire

FILE: rtl/core/cvsd_checker.sv
`default_nettype none
module cvsd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_last,
	input wire logic out_side,
	input wire logic [31:0] out_id
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("accepted while busy");
	a_sell_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_side |-> out_last) else $error("sell not last");
	a_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready ##1 out_valid && !$past(out_last) |->
		out_id == $past(out_id) + 32'd1) else $error("id gap");
endmodule

bind cross_venue_spread_signal_detector_top cvsd_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(snap.valid), .in_ready(snap.ready),
	.out_valid(res.valid), .out_ready(res.ready),
	.out_last(res.data.last), .out_side(res.data.side),
	.out_id(res.data.signal_id)
);
`default_nettype wire
